[sv/tip_pkg.sv]
// ----------------------------------------------------------------------------
// Text-to-integer parser package
// Phase codes and character constants shared by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tip_pkg;

    // Parse phase codes.
    localparam logic [2:0] PH_WS   = 3'd0;  // skipping leading whitespace
    localparam logic [2:0] PH_SDIG = 3'd1;  // signed decimal digits
    localparam logic [2:0] PH_ZERO = 3'd2;  // unsigned, leading zero seen
    localparam logic [2:0] PH_UDEC = 3'd3;  // unsigned decimal digits
    localparam logic [2:0] PH_UHEX = 3'd4;  // unsigned hex digits
    localparam logic [2:0] PH_DONE = 3'd5;  // parsing stopped

    // Characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // Register index of the mode register.
    localparam logic REG_UNSIGNED_MODE = 1'b0;

endpackage

`default_nettype wire

[sv/text_to_integer_parser.sv]
// ----------------------------------------------------------------------------
// Text-to-integer parser
// Parses a byte stream into a saturating signed or wrapping unsigned integer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] char_in, tlast = last
//  m_axis    out        tdata[63:0] value, tuser = saturated
//  APB       in/out     register 0 (byte address 0): unsigned_mode
//
//  One item is taken per cycle while the input is not stalled; the state update
//  for a byte is a multiply by ten or sixteen and one add, done in the cycle
//  the byte is accepted. The result of a string is registered on the cycle its
//  last byte is taken and appears in the following cycle. The input stalls only
//  while a result is held and the output side is not ready. Reset clears the
//  parse state and the mode register; the block is ready once reset is released.
//
`default_nettype none

module text_to_integer_parser #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic        s_axis_tlast,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] value
    output logic             m_axis_tuser,   // [0] saturated

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import tip_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int PW = VALUE_WIDTH + 4;

    localparam logic [W-1:0] VHALF = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};

    logic           unsigned_mode_reg;
    logic [2:0]     phase_reg, phase_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic           neg_reg, neg_next;
    logic           ovf_reg, ovf_next;
    logic           out_valid_reg;
    logic [W-1:0]   out_value_reg, out_value_next;
    logic           out_sat_reg, out_sat_next;

    logic [7:0]     c;
    logic           accept;
    logic           is_ws, is_dec, is_lc_hex, is_uc_hex, is_hex;
    logic [3:0]     dec_val, hex_val;
    logic [PW-1:0]  prod_dec;
    logic [PW-1:0]  prod_first;
    logic           sdig_ovf;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNSIGNED_MODE) ? {31'd0, unsigned_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unsigned_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_UNSIGNED_MODE)
        begin
            unsigned_mode_reg <= pwdata[0];
        end
    end

    // Character classes.
    assign c         = s_axis_tdata;
    assign is_ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                       (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    assign is_dec    = (c >= CH_0) && (c <= CH_9);
    assign is_lc_hex = (c >= CH_LC_A) && (c <= CH_LC_F);
    assign is_uc_hex = (c >= CH_UC_A) && (c <= CH_UC_F);
    assign is_hex    = is_dec || is_lc_hex || is_uc_hex;
    assign dec_val   = c[3:0];
    assign hex_val   = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);

    // acc * 10 + digit, kept wide enough to see signed overflow.
    assign prod_dec   = PW'({acc_reg, 3'b000}) + PW'({acc_reg, 1'b0}) + PW'(dec_val);
    // From the whitespace phase the accumulator is zero.
    assign prod_first = PW'(dec_val);
    // acc > (VHALF - d) / 10 is the same as acc * 10 + d > VHALF.
    assign sdig_ovf   = prod_dec > PW'(VHALF);

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Next parse state for the accepted byte.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        unique case (phase_reg)
            PH_WS:
            begin
                if (!is_ws)
                begin
                    if (!unsigned_mode_reg)
                    begin
                        if (c == CH_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_SDIG;
                        end
                        else if (c == CH_PLUS)
                        begin
                            phase_next = PH_SDIG;
                        end
                        else if (is_dec)
                        begin
                            phase_next = PH_SDIG;
                            acc_next   = prod_first[W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        if (c == CH_0)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else if (is_dec)
                        begin
                            phase_next = PH_UDEC;
                            acc_next   = prod_first[W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
            PH_SDIG:
            begin
                if (!is_dec)
                begin
                    phase_next = PH_DONE;
                end
                else if (sdig_ovf)
                begin
                    ovf_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next = prod_dec[W-1:0];
                end
            end
            PH_ZERO:
            begin
                if (c == CH_LC_X || c == CH_UC_X)
                begin
                    phase_next = PH_UHEX;
                end
                else if (is_dec)
                begin
                    phase_next = PH_UDEC;
                    acc_next   = prod_first[W-1:0];
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_UDEC:
            begin
                if (is_dec)
                begin
                    acc_next = prod_dec[W-1:0];
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_UHEX:
            begin
                if (is_hex)
                begin
                    acc_next = {acc_reg[W-5:0], hex_val};
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Result formatting from the state after the last byte.
    always_comb
    begin
        out_sat_next = 1'b0;
        if (unsigned_mode_reg)
        begin
            out_value_next = acc_next;
        end
        else if (neg_next)
        begin
            if (ovf_next || acc_next > VHALF)
            begin
                out_value_next = VHALF;
                out_sat_next   = 1'b1;
            end
            else
            begin
                out_value_next = W'(~acc_next + 1'b1);
            end
        end
        else
        begin
            if (ovf_next || acc_next > VMAX)
            begin
                out_value_next = VMAX;
                out_sat_next   = 1'b1;
            end
            else
            begin
                out_value_next = acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (s_axis_tlast)
                begin
                    // The string ends here: start over for the next one.
                    phase_reg <= PH_WS;
                    acc_reg   <= '0;
                    neg_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    ovf_reg   <= ovf_next;
                end
            end
            if (accept && s_axis_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 64'(out_value_reg);
    assign m_axis_tuser  = out_sat_reg;

endmodule

`default_nettype wire
